### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/u8pt_pkg.sv
package u8pt_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int OUT_BITS       = 32;
    localparam int CP_BITS        = 21;

    // Lead byte patterns.
    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD2_BITS = 8'h1F;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;
    localparam logic [7:0] LEAD4_BITS = 8'h07;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    localparam logic [CP_BITS-1:0] BMP_MAX   = 21'h00FFFF;
    localparam logic [CP_BITS-1:0] LINE_FEED = 21'h00000A;

    typedef struct packed {
        logic [OUT_BITS-1:0] start_offset;
        logic [OUT_BITS-1:0] line_number;
        logic [OUT_BITS-1:0] column_number;
        logic [OUT_BITS-1:0] u16_offset;
        logic [CP_BITS-1:0]  cp_value;
        logic                is_end;
        logic                last;
    } t_rec;

endpackage

### rtl/u8pt_if.sv
interface u8pt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface u8pt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] start_offset;
    logic [31:0] line_number;
    logic [31:0] column_number;
    logic [31:0] u16_offset;
    logic [20:0] cp_value;
    logic        is_end;
    logic        last;

    modport source (output valid, output start_offset, output line_number,
                    output column_number, output u16_offset, output cp_value,
                    output is_end, output last, input ready);
    modport sink   (input valid, input start_offset, input line_number,
                    input column_number, input u16_offset, input cp_value,
                    input is_end, input last, output ready);
endinterface

### rtl/u8pt_core.sv
module u8pt_core #(
    parameter int COUNT_BITS = u8pt_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_text_byte,
    input  logic              i_final_byte,
    output u8pt_pkg::t_rec    o_rec0,
    output u8pt_pkg::t_rec    o_rec1,
    output logic [1:0]        o_count
);
    import u8pt_pkg::*;

    logic [COUNT_BITS-1:0] r_byte_count, n_byte_count;
    logic [COUNT_BITS-1:0] r_seq_start,  n_seq_start;
    logic [COUNT_BITS-1:0] r_line,       n_line;
    logic [COUNT_BITS-1:0] r_col,        n_col;
    logic [COUNT_BITS-1:0] r_units,      n_units;
    logic [CP_BITS-1:0]    r_pv,         n_pv;
    logic [1:0]            r_rem,        n_rem;

    logic                  done;
    logic [1:0]            cp_units;
    logic [COUNT_BITS-1:0] upd_line, upd_col, upd_units;
    t_rec                  cp_rec, end_rec;

    function automatic logic [COUNT_BITS-1:0] f_sat_add(
        input logic [COUNT_BITS-1:0] x,
        input logic [1:0]            k
    );
        logic [COUNT_BITS:0] s;
        s = {1'b0, x} + {{(COUNT_BITS-1){1'b0}}, k};
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    always_comb begin
        n_seq_start = r_seq_start;
        n_pv        = r_pv;
        n_rem       = r_rem;
        if (r_rem == 2'd0) begin
            n_seq_start = r_byte_count;
            if (i_text_byte <= ASCII_MAX) begin
                n_pv  = CP_BITS'(i_text_byte);
                n_rem = 2'd0;
            end else if ((i_text_byte & LEAD2_MASK) == LEAD2_PAT) begin
                n_pv  = CP_BITS'(i_text_byte & LEAD2_BITS);
                n_rem = 2'd1;
            end else if ((i_text_byte & LEAD3_MASK) == LEAD3_PAT) begin
                n_pv  = CP_BITS'(i_text_byte & LEAD3_BITS);
                n_rem = 2'd2;
            end else begin
                // Anything else, stray continuation bytes included, opens four bytes.
                n_pv  = CP_BITS'(i_text_byte & LEAD4_BITS);
                n_rem = 2'd3;
            end
        end else begin
            n_pv  = CP_BITS'({r_pv, i_text_byte[5:0] & CONT_BITS[5:0]});
            n_rem = r_rem - 2'd1;
        end
        done         = (n_rem == 2'd0);
        n_byte_count = f_sat_add(r_byte_count, 2'd1);

        cp_units  = (n_pv > BMP_MAX) ? 2'd2 : 2'd1;
        upd_units = r_units;
        upd_line  = r_line;
        upd_col   = r_col;
        if (done) begin
            upd_units = f_sat_add(r_units, cp_units);
            if (n_pv == LINE_FEED) begin
                upd_line = f_sat_add(r_line, 2'd1);
                upd_col  = COUNT_BITS'(1);
            end else begin
                upd_col  = f_sat_add(r_col, cp_units);
            end
        end

        cp_rec.start_offset  = OUT_BITS'(n_seq_start);
        cp_rec.line_number   = OUT_BITS'(r_line);
        cp_rec.column_number = OUT_BITS'(r_col);
        cp_rec.u16_offset    = OUT_BITS'(r_units);
        cp_rec.cp_value      = n_pv;
        cp_rec.is_end        = 1'b0;
        cp_rec.last          = !i_final_byte;

        end_rec.start_offset  = OUT_BITS'(n_byte_count);
        end_rec.line_number   = OUT_BITS'(upd_line);
        end_rec.column_number = OUT_BITS'(upd_col);
        end_rec.u16_offset    = OUT_BITS'(upd_units);
        end_rec.cp_value      = '0;
        end_rec.is_end        = 1'b1;
        end_rec.last          = 1'b1;

        o_rec0  = done ? cp_rec : end_rec;
        o_rec1  = end_rec;
        o_count = {1'b0, done} + {1'b0, i_final_byte};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_seq_start  <= '0;
            r_line       <= COUNT_BITS'(1);
            r_col        <= COUNT_BITS'(1);
            r_units      <= '0;
            r_pv         <= '0;
            r_rem        <= 2'd0;
        end else if (i_fire) begin
            if (i_final_byte) begin
                // The end record closes the text and the next byte starts a new one.
                r_byte_count <= '0;
                r_seq_start  <= '0;
                r_line       <= COUNT_BITS'(1);
                r_col        <= COUNT_BITS'(1);
                r_units      <= '0;
                r_pv         <= '0;
                r_rem        <= 2'd0;
            end else begin
                r_byte_count <= n_byte_count;
                r_seq_start  <= n_seq_start;
                r_line       <= upd_line;
                r_col        <= upd_col;
                r_units      <= upd_units;
                r_pv         <= done ? '0 : n_pv;
                r_rem        <= n_rem;
            end
        end
    end

endmodule

### rtl/utf8_position_tracker.sv
// UTF-8 position tracker.
// The input channel takes one byte of UTF-8 text per beat, with final_byte set on the
// last byte of a text. The output channel gives one record per completed code point:
// its start byte offset, the line, UTF-16 column and UTF-16 offset before it, and its
// value. The final byte is followed by an end record with is_end set, carrying the total
// byte count and the position after the text; last marks the final record of a byte.
// A byte is held in the input register and then decoded into a four-entry result
// queue, from which its records are offered on the output channel.
// Throughput is one byte per cycle while the queue has room, limited by the single
// update of the position counters per cycle; a byte that yields both a code point and
// the end record puts two records into the queue.
// The input register only moves into the queue when two entries are free, so a
// stalled receiver fills the queue and then drops input ready; nothing is lost.
// Reset empties the queue and the input register and returns the counters to the
// start of a text (line 1, column 1, offsets 0). A truncated last sequence is dropped.
module utf8_position_tracker #(
    parameter int COUNT_BITS = u8pt_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    u8pt_in_if.sink           i_in,
    u8pt_out_if.source        o_out
);
    import u8pt_pkg::*;

    localparam int DEPTH = 4;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;
    logic       fire;

    t_rec       rec0, rec1;
    logic [1:0] push_count;

    t_rec       r_mem [DEPTH];
    logic [1:0] r_wr_ptr, r_rd_ptr;
    logic [2:0] r_fill, n_fill;
    logic       pop;

    assign fire       = r_in_valid && (r_fill <= 3'd2);
    assign i_in.ready = !r_in_valid || fire;
    assign pop        = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte  <= i_in.text_byte;
            r_in_final <= i_in.final_byte;
        end
    end

    u8pt_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_text_byte  (r_in_byte),
        .i_final_byte (r_in_final),
        .o_rec0       (rec0),
        .o_rec1       (rec1),
        .o_count      (push_count)
    );

    always_comb begin
        n_fill = r_fill - {2'b00, pop};
        if (fire) begin
            n_fill = n_fill + {1'b0, push_count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_fill <= n_fill;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            if (fire) begin
                r_wr_ptr <= r_wr_ptr + push_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && (push_count != 2'd0)) begin
            r_mem[r_wr_ptr] <= rec0;
        end
        if (fire && (push_count == 2'd2)) begin
            r_mem[r_wr_ptr + 2'd1] <= rec1;
        end
    end

    assign o_out.valid         = (r_fill != 3'd0);
    assign o_out.start_offset  = r_mem[r_rd_ptr].start_offset;
    assign o_out.line_number   = r_mem[r_rd_ptr].line_number;
    assign o_out.column_number = r_mem[r_rd_ptr].column_number;
    assign o_out.u16_offset    = r_mem[r_rd_ptr].u16_offset;
    assign o_out.cp_value      = r_mem[r_rd_ptr].cp_value;
    assign o_out.is_end        = r_mem[r_rd_ptr].is_end;
    assign o_out.last          = r_mem[r_rd_ptr].last;

endmodule

### rtl/u8pt_checker.sv
`include "assert_macros.svh"

module u8pt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8pt_in_if.sink     i_in,
    u8pt_out_if.source  o_out
);

    // The queue is empty and the input is open right after reset.
    `ASSERT_ALWAYS(a_idle_after_reset, i_clk,
                   !i_rst_n |=> !o_out.valid && i_in.ready, "block not idle after reset")

    // An end record carries no code point and always closes its byte.
    `ASSERT_CLK(a_end_shape, i_clk, i_rst_n,
                o_out.valid && o_out.is_end |-> o_out.cp_value == 21'd0 && o_out.last,
                "malformed end record")

    // A code point that is not the last record of its byte is followed by the end record.
    `ASSERT_CLK(a_end_follows, i_clk, i_rst_n,
                o_out.valid && o_out.ready && !o_out.last |=> o_out.valid && o_out.is_end,
                "end record missing after code point")

    // A stalled beat keeps its record.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
                o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.start_offset) && $stable(o_out.cp_value),
                "stalled output changed")

endmodule

bind utf8_position_tracker u8pt_checker u_u8pt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);
